@@ hdl/u8v_pkg.sv @@
// Shared types, codes and constants for the UTF-8 stream validator.
// No dependencies; imported by the result channel interface, the core and the testbench.
`default_nettype none

package u8v_pkg;

  // Error codes, first error of a string only
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_LEAD = 3'd1,
    ERR_TRAIL    = 3'd2,
    ERR_OVERLONG = 3'd3,
    ERR_RANGE    = 3'd4
  } err_t;

  // Byte pattern constants
  localparam logic [7:0] LEAD_FOLD_MASK  = 8'hEF;  // folds E0 and F0 together
  localparam logic [7:0] LEAD_FOLD_MATCH = 8'hE0;
  localparam logic [7:0] LEAD_MAX        = 8'hF4;  // lead of the top plane block
  localparam logic [7:0] TRAIL_MASK      = 8'hC0;
  localparam logic [7:0] TRAIL_MATCH     = 8'h80;
  localparam logic [7:0] BITS_4BYTE      = 8'h30;
  localparam logic [7:0] BITS_3BYTE      = 8'h20;

  // Lead byte decode result
  typedef struct packed {
    logic       ok;
    logic [1:0] trails;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r.ok     = 1'b1;
    r.trails = 2'd0;
    if (b inside {[8'h00:8'h7F]}) begin
      r.trails = 2'd0;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      r.trails = 2'd1;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      r.trails = 2'd2;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      r.trails = 2'd3;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/u8v_in_if.sv @@
// Input byte channel: valid/ready handshake with one string byte per item.
// Depends on nothing but the language; stands after u8v_pkg.
`default_nettype none

interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink   (input valid, input byte_in, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/u8v_out_if.sv @@
// Result channel: valid/ready handshake with one check result per item.
// Depends on u8v_pkg for the error code type.
`default_nettype none

interface u8v_out_if
  import u8v_pkg::*;
;
  logic valid;
  logic ready;
  err_t error_code;
  logic string_end;
  logic string_valid;

  modport source (output valid, output error_code, output string_end,
                  output string_valid, input ready);
  modport sink   (input valid, input error_code, input string_end,
                  input string_valid, output ready);
endinterface

`default_nettype wire

@@ hdl/utf8_stream_validator_core.sv @@
// UTF-8 stream validator, top level.
// Depends on u8v_pkg, u8v_in_if and u8v_out_if.
//
// Usage:
//   stream carries one byte of a UTF-8 string per item, with last set on
//   the final byte. report returns exactly one item per input byte: the
//   error code if this byte raised the first error of its string, an echo
//   of last, and on the last byte whether the whole string was valid.
//   A byte's result is registered and valid in the cycle after the byte is
//   accepted. Throughput is one byte per cycle while report takes its items,
//   set by the single decode step between the sequence state and the result register.
//   When report stalls, the result register holds its item and stream
//   ready drops until it is taken; a byte is accepted in the same cycle
//   the held result leaves. Synchronous reset clears the sequence state
//   and the result valid; the state also returns to reset after every
//   last byte, so strings are checked independently.
`default_nettype none

module utf8_stream_validator_core
  import u8v_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  u8v_in_if.sink    stream,
  u8v_out_if.source report
);

  // Sequence state
  logic [1:0] trails_left, trails_left_next;
  logic [7:0] overlong_mask, overlong_mask_next;
  logic [7:0] range_mask, range_mask_next;
  logic       error_seen, error_seen_next;

  // Result register
  logic       out_valid;
  err_t       out_code, code_next;
  logic       out_end;
  logic       out_ok, ok_next;

  logic       take;
  lead_t      lead;

  assign stream.ready = !out_valid || report.ready;
  assign take         = stream.valid && stream.ready;
  assign lead         = lead_decode(stream.byte_in);

  // Decode one byte against the pending sequence state
  always_comb begin
    code_next          = ERR_NONE;
    trails_left_next   = trails_left;
    overlong_mask_next = overlong_mask;
    range_mask_next    = range_mask;
    error_seen_next    = error_seen;
    if (!error_seen) begin
      if (trails_left == 2'd0) begin
        if (!lead.ok) begin
          code_next = ERR_BAD_LEAD;
        end else begin
          trails_left_next   = lead.trails;
          overlong_mask_next = 8'h00;
          if ((stream.byte_in & LEAD_FOLD_MASK) == LEAD_FOLD_MATCH) begin
            overlong_mask_next = (lead.trails == 2'd2) ? BITS_3BYTE : BITS_4BYTE;
          end
          range_mask_next = (stream.byte_in == LEAD_MAX) ? BITS_4BYTE : 8'h00;
        end
      end else begin
        if ((stream.byte_in & TRAIL_MASK) != TRAIL_MATCH) begin
          code_next = ERR_TRAIL;
        end else if (overlong_mask != 8'h00 &&
                     (stream.byte_in & overlong_mask) == 8'h00) begin
          code_next = ERR_OVERLONG;
        end else if (range_mask != 8'h00 &&
                     (stream.byte_in & range_mask) != 8'h00) begin
          code_next = ERR_RANGE;
        end else begin
          overlong_mask_next = 8'h00;
          range_mask_next    = 8'h00;
          trails_left_next   = trails_left - 2'd1;
        end
      end
      // string ends mid-sequence
      if (code_next == ERR_NONE && stream.last && trails_left_next != 2'd0) begin
        code_next = ERR_TRAIL;
      end
      if (code_next != ERR_NONE) begin
        error_seen_next    = 1'b1;
        trails_left_next   = 2'd0;
        overlong_mask_next = 8'h00;
        range_mask_next    = 8'h00;
      end
    end
    ok_next = stream.last && !error_seen_next;
    // new string starts clean
    if (stream.last) begin
      trails_left_next   = 2'd0;
      overlong_mask_next = 8'h00;
      range_mask_next    = 8'h00;
      error_seen_next    = 1'b0;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trails_left   <= 2'd0;
      overlong_mask <= 8'h00;
      range_mask    <= 8'h00;
      error_seen    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        trails_left   <= trails_left_next;
        overlong_mask <= overlong_mask_next;
        range_mask    <= range_mask_next;
        error_seen    <= error_seen_next;
        out_valid     <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      out_code <= code_next;
      out_end  <= stream.last;
      out_ok   <= ok_next;
    end
  end

  assign report.valid        = out_valid;
  assign report.error_code   = out_code;
  assign report.string_end   = out_end;
  assign report.string_valid = out_ok;

endmodule

`default_nettype wire

@@ sim/tb_utf8_stream_validator_core.sv @@
// Self-checking testbench for utf8_stream_validator_core: byte strings in, one check item out.
// Depends on u8v_pkg, u8v_in_if, u8v_out_if and the core; predicts every result internally.
`default_nettype none

module tb_utf8_stream_validator_core
  import u8v_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    err_t code;
    logic fin;
    logic ok;
  } check_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8v_in_if  stream_ch ();
  u8v_out_if report_ch ();

  utf8_stream_validator_core dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .report (report_ch)
  );

  // Predictor state for the sequence being decoded
  logic [1:0] seq_trails  = 2'd0;
  logic [7:0] ovl_mask    = 8'h00;
  logic [7:0] rng_mask    = 8'h00;
  logic       err_latched = 1'b0;

  check_t     pending_checks[$];
  logic [7:0] str_bytes[$];
  int         fail_count  = 0;
  int         src_idle    = 0;
  int         sink_idle   = 0;
  int         hold_left   = 0;
  int         bytes_sent  = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Next check item for one byte; advances the predictor state
  function automatic check_t predict_check(input logic [7:0] b, input logic fin);
    check_t r;
    int     n;
    r.code = ERR_NONE;
    n = -1;
    if (!err_latched) begin
      if (seq_trails == 2'd0) begin
        if (b < 8'h80)      n = 0;
        else if (b < 8'hC2) n = -1;
        else if (b < 8'hE0) n = 1;
        else if (b < 8'hF0) n = 2;
        else if (b < 8'hF5) n = 3;
        if (n < 0) begin
          r.code = ERR_BAD_LEAD;
        end else begin
          seq_trails = n[1:0];
          ovl_mask   = 8'h00;
          if ((b & LEAD_FOLD_MASK) == LEAD_FOLD_MATCH)
            ovl_mask = (n == 2) ? BITS_3BYTE : BITS_4BYTE;
          rng_mask = (b == LEAD_MAX) ? BITS_4BYTE : 8'h00;
        end
      end else begin
        if ((b & TRAIL_MASK) != TRAIL_MATCH) begin
          r.code = ERR_TRAIL;
        end else if (ovl_mask != 8'h00 && (b & ovl_mask) == 8'h00) begin
          r.code = ERR_OVERLONG;
        end else if (rng_mask != 8'h00 && (b & rng_mask) != 8'h00) begin
          r.code = ERR_RANGE;
        end else begin
          ovl_mask   = 8'h00;
          rng_mask   = 8'h00;
          seq_trails = seq_trails - 2'd1;
        end
      end
      // string ends with trail bytes still owed
      if (r.code == ERR_NONE && fin && seq_trails != 2'd0)
        r.code = ERR_TRAIL;
      if (r.code != ERR_NONE) begin
        err_latched = 1'b1;
        seq_trails  = 2'd0;
        ovl_mask    = 8'h00;
        rng_mask    = 8'h00;
      end
    end
    r.fin = fin;
    r.ok  = fin && !err_latched;
    // every string starts from a clean state
    if (fin) begin
      seq_trails  = 2'd0;
      ovl_mask    = 8'h00;
      rng_mask    = 8'h00;
      err_latched = 1'b0;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Predict on accepted bytes, check accepted results (predict first so
  // a same-edge result still finds its expectation)
  always @(posedge clk) begin
    check_t want;
    if (!rst) begin
      if (stream_ch.valid && stream_ch.ready)
        pending_checks.push_back(predict_check(stream_ch.byte_in, stream_ch.last));
      if (report_ch.valid && report_ch.ready) begin
        if (pending_checks.size() == 0) begin
          note_failure($sformatf("result with nothing pending: code %0d end %0b valid %0b",
                                 report_ch.error_code, report_ch.string_end,
                                 report_ch.string_valid));
        end else begin
          want = pending_checks.pop_front();
          if (report_ch.error_code !== want.code || report_ch.string_end !== want.fin ||
              report_ch.string_valid !== want.ok)
            note_failure($sformatf("exp code %0d end %0b valid %0b, got code %0d end %0b valid %0b",
                                   want.code, want.fin, want.ok, report_ch.error_code,
                                   report_ch.string_end, report_ch.string_valid));
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles
  always @(posedge clk) begin
    if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  // Receiver readiness
  always @(negedge clk) begin
    report_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_idle);
  end

  // Offer one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < src_idle) begin
      stream_ch.valid <= 1'b0;
      @(negedge clk);
    end
    stream_ch.valid   <= 1'b1;
    stream_ch.byte_in <= b;
    stream_ch.last    <= fin;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string();
    foreach (str_bytes[i])
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // Append one sequence: mostly well formed, some noise and broken forms
  task automatic append_sequence();
    int         kind;
    logic [7:0] lead;
    kind = $urandom_range(0, 99);
    if (kind < 82) begin
      case ($urandom_range(1, 4))
        1: str_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
        2: begin
          str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
          str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        3: begin
          lead = 8'($urandom_range(8'hE0, 8'hEF));
          str_bytes.push_back(lead);
          str_bytes.push_back(lead == 8'hE0 ? 8'($urandom_range(8'hA0, 8'hBF))
                                            : 8'($urandom_range(8'h80, 8'hBF)));
          str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          lead = 8'($urandom_range(8'hF0, 8'hF4));
          str_bytes.push_back(lead);
          if (lead == 8'hF0)      str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
          else if (lead == 8'hF4) str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
          else                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
    end else if (kind < 90) begin
      str_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      // truncated multi-byte sequence
      str_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
      if ($urandom_range(0, 1))
        str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      // lead with an overlong or range check, then any first trail
      case ($urandom_range(0, 2))
        0:       lead = 8'hE0;
        1:       lead = 8'hF0;
        default: lead = LEAD_MAX;
      endcase
      str_bytes.push_back(lead);
      str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
  endtask

  task automatic send_random_string();
    str_bytes = {};
    repeat ($urandom_range(1, 5)) append_sequence();
    send_string();
  endtask

  // Stop offering, then wait until every result is back
  task automatic wait_drain();
    stream_ch.valid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes, every error code and the named corner cases
  task automatic test_directed();
    src_idle  = 0;
    sink_idle = 0;
    str_bytes = {8'h00, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'h7F};  // valid, extremes
    send_string();
    str_bytes = {8'hE0, 8'h9F, 8'h80};                      // 3-byte overlong, then latched
    send_string();
    str_bytes = {8'hF0, 8'h8F};                             // 4-byte overlong
    send_string();
    str_bytes = {8'hF4, 8'h90};                             // above 0x10FFFF
    send_string();
    str_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};               // top code point
    send_string();
    str_bytes = {8'hED, 8'hA0, 8'h80};                      // surrogate accepted
    send_string();
    str_bytes = {8'hC2, 8'h41};                             // non-trail byte
    send_string();
    str_bytes = {8'hE0};                                    // trails missing at end
    send_string();
    str_bytes = {8'h80};                                    // invalid leads, one per string
    send_string();
    str_bytes = {8'hC0};
    send_string();
    str_bytes = {8'hC1};
    send_string();
    str_bytes = {8'hF5};
    send_string();
    str_bytes = {8'hFF};
    send_string();
    wait_drain();
  endtask

  task automatic test_random_strings(input int src_pct, input int sink_pct, input int n_bytes);
    int stop_at;
    src_idle  = src_pct;
    sink_idle = sink_pct;
    stop_at   = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_string();
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int stop_at;
    src_idle  = 0;
    sink_idle = 0;
    hold_left <= 80;
    stop_at   = bytes_sent + 40;
    while (bytes_sent < stop_at) send_random_string();
    wait_drain();
  endtask

  initial begin
    stream_ch.valid   = 1'b0;
    stream_ch.byte_in = 8'h00;
    stream_ch.last    = 1'b0;
    report_ch.ready   = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_strings(31, 64, 250);
    test_random_strings(64, 31, 250);
    test_random_strings(0, 0, 250);
    test_backpressure();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[%0t] timeout, %0d results outstanding", $realtime, pending_checks.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ utf8_stream_validator_core.f @@
hdl/u8v_pkg.sv
hdl/u8v_in_if.sv
hdl/u8v_out_if.sv
hdl/utf8_stream_validator_core.sv
sim/tb_utf8_stream_validator_core.sv
